[hdl/wtlc_pkg.sv]
// Package for the window tile layout compositor.
// Holds sizes, codes, sequencer states and the result record types.
// No dependencies.
package wtlc_pkg;

  localparam int unsigned MaxTiles = 16;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned CntW     = 5;
  localparam int unsigned AccW     = 20;  // widest canvas sum before the range check
  localparam int unsigned ExtW     = 18;  // signed bounding box edges

  // configuration register indexes
  localparam logic [1:0] CfgLayoutMode  = 2'd0;
  localparam logic [1:0] CfgPadding     = 2'd1;
  localparam logic [1:0] CfgGridColumns = 2'd2;

  typedef enum logic [1:0] {
    MODE_BBOX = 2'd0,
    MODE_ROW  = 2'd1,
    MODE_COL  = 2'd2,
    MODE_GRID = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RANK,
    ST_SUM,
    ST_GRIDC,
    ST_GRIDR,
    ST_FIN,
    ST_CHK,
    ST_PLACE,
    ST_EMIT
  } state_e;

  // one tile as seen by the result formatter
  typedef struct packed {
    logic [IdxW-1:0] tile_number;
    logic [13:0]     width;
    logic [13:0]     height;
    logic [15:0]     dx;
    logic [15:0]     dy;
    logic [15:0]     canvas_width;
    logic [15:0]     canvas_height;
    logic [15:0]     canvas_left;
    logic [15:0]     canvas_top;
    logic            canvas_ok;
    logic            last;
  } emit_in_t;

  typedef struct packed {
    logic [IdxW-1:0] tile_number;
    logic [13:0]     source_x;
    logic [13:0]     source_y;
    logic [15:0]     dest_x;
    logic [15:0]     dest_y;
    logic [13:0]     copy_width;
    logic [13:0]     copy_height;
    logic [15:0]     canvas_width;
    logic [15:0]     canvas_height;
    logic [15:0]     canvas_left;
    logic [15:0]     canvas_top;
    logic            last_result;
  } result_t;

endpackage

[hdl/wtlc_emit.sv]
// Result formatter: gates one copy rectangle by canvas status and tile size.
// Depends on wtlc_pkg.
module wtlc_emit import wtlc_pkg::*; (
  input  emit_in_t tile_i,
  output result_t  res_o
);

  logic show;

  assign show = tile_i.canvas_ok && (tile_i.width != '0) && (tile_i.height != '0);

  always_comb begin
    res_o               = '0;
    res_o.tile_number   = tile_i.tile_number;
    res_o.last_result   = tile_i.last;
    if (tile_i.canvas_ok) begin
      res_o.canvas_width  = tile_i.canvas_width;
      res_o.canvas_height = tile_i.canvas_height;
      res_o.canvas_left   = tile_i.canvas_left;
      res_o.canvas_top    = tile_i.canvas_top;
    end
    if (show) begin
      res_o.dest_x      = tile_i.dx;
      res_o.dest_y      = tile_i.dy;
      res_o.copy_width  = tile_i.width;
      res_o.copy_height = tile_i.height;
    end
  end

endmodule

[hdl/window_tile_layout_compositor.sv]
// Window tile layout compositor, top level.
// Depends on wtlc_pkg and wtlc_emit.
//
// Usage:
//   Load tiles with start_i while busy_o is low, one item per cycle. Each
//   item carries a tile's position, size and depth. Up to sixteen tiles are
//   kept; later ones are dropped. The item with last_tile_i set closes the
//   set and starts the computation; busy_o then stays high until the last
//   copy rectangle is on the result ports.
//   Computation runs under one sequencer, in these phases:
//     rank   : one depth compare per cycle (stable sort)
//     sum    : one pass over the sorted tiles (extents, row/column maxima)
//     grid   : column positions, then row positions, grid mode only
//     finish : canvas select, then even rounding and range check
//     place  : one pass over the tiles, emit : one pass over the tiles
//   Results appear one per cycle on the result ports with result_valid_o
//   high for exactly one cycle; the receiver cannot stall them.
//   Configuration writes (cfg_we_i) are taken at any edge, but only apply
//   cleanly between sets. Reset clears the sequencer and the tile count,
//   and loads the register defaults (bounding box, padding 8, two columns).
module window_tile_layout_compositor import wtlc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] tile_left_i,
  input  logic signed [15:0] tile_top_i,
  input  logic [13:0]        tile_width_i,
  input  logic [13:0]        tile_height_i,
  input  logic [15:0]        depth_order_i,
  input  logic               last_tile_i,
  output logic               result_valid_o,
  output logic [3:0]         tile_number_o,
  output logic [13:0]        source_x_o,
  output logic [13:0]        source_y_o,
  output logic [15:0]        dest_x_o,
  output logic [15:0]        dest_y_o,
  output logic [13:0]        copy_width_o,
  output logic [13:0]        copy_height_o,
  output logic [15:0]        canvas_width_o,
  output logic [15:0]        canvas_height_o,
  output logic signed [15:0] canvas_left_o,
  output logic signed [15:0] canvas_top_o,
  output logic               last_result_o
);

  // configuration
  mode_e      mode_q;
  logic [7:0] pad_q;
  logic [4:0] gcols_q;
  logic [4:0] cols;

  // tile store
  logic signed [15:0] left_q  [MaxTiles];
  logic signed [15:0] top_q   [MaxTiles];
  logic [13:0]        w_q     [MaxTiles];
  logic [13:0]        h_q     [MaxTiles];
  logic [15:0]        dep_q   [MaxTiles];
  logic [IdxW-1:0]    order_q [MaxTiles];
  logic [13:0]        colw_q  [MaxTiles];
  logic [13:0]        rowh_q  [MaxTiles];
  logic [15:0]        colx_q  [MaxTiles];
  logic [15:0]        rowy_q  [MaxTiles];
  logic [15:0]        dx_q    [MaxTiles];
  logic [15:0]        dy_q    [MaxTiles];

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, n_q;
  logic [IdxW-1:0] k_q, j_q, acc_q, gr_q, lastrow_q;
  logic [4:0]      gc_q;
  logic [AccW-1:0] cw_q, ch_q, pos_q;
  logic signed [ExtW-1:0] bl_q, bt_q, br_q, bb_q;
  logic [15:0] cl_q, ct_q;
  logic        ok_q;

  logic accept, k_last, j_last, c_last, r_last;
  logic [IdxW-1:0] t, t_emit, emit_idx, acc_nx;
  logic hit;
  logic signed [ExtW-1:0] le, te, re, be;
  logic [AccW-1:0] cw_r, ch_r;
  logic [18:0] bw, bh;

  emit_in_t ein;
  result_t  res;

  assign cols   = (gcols_q == '0) ? 5'd1 : gcols_q;
  assign accept = start_i && (state_q == ST_LOAD);
  assign k_last = ({1'b0, k_q} == n_q - 5'd1);
  assign j_last = ({1'b0, j_q} == n_q - 5'd1);
  assign c_last = (gc_q == cols - 5'd1) || (gc_q == n_q - 5'd1);
  assign r_last = (gr_q == lastrow_q);

  // stable rank: count earlier-drawn tiles
  assign hit    = (dep_q[j_q] < dep_q[k_q]) || ((j_q < k_q) && (dep_q[j_q] == dep_q[k_q]));
  assign acc_nx = acc_q + IdxW'(hit);

  assign t  = order_q[k_q];
  assign le = ExtW'(left_q[t]);
  assign te = ExtW'(top_q[t]);
  assign re = le + ExtW'({1'b0, w_q[t]});
  assign be = te + ExtW'({1'b0, h_q[t]});

  assign bw = 19'(br_q - bl_q);
  assign bh = 19'(bb_q - bt_q);
  assign cw_r = (n_q == 5'd1) ? cw_q : cw_q + AccW'(cw_q[0]);
  assign ch_r = (n_q == 5'd1) ? ch_q : ch_q + AccW'(ch_q[0]);

  assign emit_idx = (mode_q == MODE_BBOX && n_q != 5'd1) ? n_q[IdxW-1:0] - 4'd1 - k_q : k_q;
  assign t_emit   = order_q[emit_idx];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (accept && last_tile_i) state_d = ST_RANK;
      ST_RANK:  if (j_last && k_last) state_d = ST_SUM;
      ST_SUM:   if (k_last) state_d = (mode_q == MODE_GRID) ? ST_GRIDC : ST_FIN;
      ST_GRIDC: if (c_last) state_d = ST_GRIDR;
      ST_GRIDR: if (r_last) state_d = ST_FIN;
      ST_FIN:   state_d = ST_CHK;
      ST_CHK:   state_d = ST_PLACE;
      ST_PLACE: if (k_last) state_d = ST_EMIT;
      ST_EMIT:  if (k_last) state_d = ST_LOAD;
      default:  state_d = ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy_o = (state_q != ST_LOAD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      mode_q  <= MODE_BBOX;
      pad_q   <= 8'd8;
      gcols_q <= 5'd2;
      count_q <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      result_valid_o <= (state_q == ST_EMIT);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgLayoutMode:  mode_q  <= mode_e'(cfg_data_i[1:0]);
          CfgPadding:     pad_q   <= cfg_data_i;
          CfgGridColumns: gcols_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (accept) begin
        // drop tiles past the store, close the set on the last one
        if (last_tile_i) count_q <= '0;
        else if (!count_q[CntW-1]) count_q <= count_q + 5'd1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (!count_q[CntW-1]) begin
            left_q[count_q[IdxW-1:0]] <= tile_left_i;
            top_q[count_q[IdxW-1:0]]  <= tile_top_i;
            w_q[count_q[IdxW-1:0]]    <= tile_width_i;
            h_q[count_q[IdxW-1:0]]    <= tile_height_i;
            dep_q[count_q[IdxW-1:0]]  <= depth_order_i;
          end
          n_q   <= count_q + (count_q[CntW-1] ? 5'd0 : 5'd1);
          k_q   <= '0;
          j_q   <= '0;
          acc_q <= '0;
        end
      end
      ST_RANK: begin
        if (j_last) begin
          order_q[acc_nx] <= k_q;
          acc_q <= '0;
          j_q   <= '0;
          k_q   <= k_last ? '0 : k_q + 4'd1;
          if (k_last) begin
            gc_q <= '0;
            gr_q <= '0;
            lastrow_q <= '0;
            cw_q <= '0;
            ch_q <= '0;
            for (int i = 0; i < MaxTiles; i++) begin
              colw_q[i] <= '0;
              rowh_q[i] <= '0;
            end
          end
        end else begin
          acc_q <= acc_nx;
          j_q   <= j_q + 4'd1;
        end
      end
      ST_SUM: begin
        unique case (mode_q)
          MODE_BBOX: begin
            if (k_q == '0 || le < bl_q) bl_q <= le;
            if (k_q == '0 || te < bt_q) bt_q <= te;
            if (k_q == '0 || re > br_q) br_q <= re;
            if (k_q == '0 || be > bb_q) bb_q <= be;
          end
          MODE_ROW: begin
            cw_q <= cw_q + AccW'(w_q[t]) + (k_last ? '0 : AccW'(pad_q));
            if (AccW'(h_q[t]) > ch_q) ch_q <= AccW'(h_q[t]);
          end
          MODE_COL: begin
            ch_q <= ch_q + AccW'(h_q[t]) + (k_last ? '0 : AccW'(pad_q));
            if (AccW'(w_q[t]) > cw_q) cw_q <= AccW'(w_q[t]);
          end
          MODE_GRID: begin
            if (w_q[t] > colw_q[gc_q[IdxW-1:0]]) colw_q[gc_q[IdxW-1:0]] <= w_q[t];
            if (h_q[t] > rowh_q[gr_q]) rowh_q[gr_q] <= h_q[t];
            lastrow_q <= gr_q;
            if (gc_q == cols - 5'd1) begin
              gc_q <= '0;
              gr_q <= gr_q + 4'd1;
            end else begin
              gc_q <= gc_q + 5'd1;
            end
          end
          default: ;
        endcase
        k_q <= k_last ? '0 : k_q + 4'd1;
        if (k_last) begin
          gc_q  <= '0;
          gr_q  <= '0;
          pos_q <= '0;
        end
      end
      ST_GRIDC: begin
        colx_q[gc_q[IdxW-1:0]] <= pos_q[15:0];
        if (c_last) begin
          cw_q  <= cw_q + AccW'(colw_q[gc_q[IdxW-1:0]])
                   + AccW'(pad_q) * AccW'(cols - 5'd1);
          pos_q <= '0;
        end else begin
          cw_q  <= cw_q + AccW'(colw_q[gc_q[IdxW-1:0]]);
          pos_q <= pos_q + AccW'(colw_q[gc_q[IdxW-1:0]]) + AccW'(pad_q);
          gc_q  <= gc_q + 5'd1;
        end
      end
      ST_GRIDR: begin
        rowy_q[gr_q] <= pos_q[15:0];
        if (r_last) begin
          ch_q <= ch_q + AccW'(rowh_q[gr_q]) + AccW'(pad_q) * AccW'(lastrow_q);
        end else begin
          ch_q  <= ch_q + AccW'(rowh_q[gr_q]);
          pos_q <= pos_q + AccW'(rowh_q[gr_q]) + AccW'(pad_q);
          gr_q  <= gr_q + 4'd1;
        end
      end
      ST_FIN: begin
        // a lone tile is its own canvas
        if (n_q == 5'd1) begin
          cw_q <= AccW'(w_q[0]);
          ch_q <= AccW'(h_q[0]);
          cl_q <= left_q[0];
          ct_q <= top_q[0];
        end else if (mode_q == MODE_BBOX) begin
          cw_q <= AccW'(bw);
          ch_q <= AccW'(bh);
          cl_q <= bl_q[15:0];
          ct_q <= bt_q[15:0];
        end else begin
          cl_q <= '0;
          ct_q <= '0;
        end
      end
      ST_CHK: begin
        cw_q  <= cw_r;
        ch_q  <= ch_r;
        ok_q  <= (cw_r != '0) && (ch_r != '0) && (cw_r <= AccW'(16'hFFFF))
                 && (ch_r <= AccW'(16'hFFFF));
        k_q   <= '0;
        gc_q  <= '0;
        gr_q  <= '0;
        pos_q <= '0;
      end
      ST_PLACE: begin
        if (n_q == 5'd1) begin
          dx_q[t] <= '0;
          dy_q[t] <= '0;
        end else begin
          unique case (mode_q)
            MODE_BBOX: begin
              dx_q[t] <= left_q[t] - cl_q;
              dy_q[t] <= top_q[t] - ct_q;
            end
            MODE_ROW: begin
              dx_q[t] <= pos_q[15:0];
              dy_q[t] <= 16'((ch_q - AccW'(h_q[t])) >> 1);
              pos_q   <= pos_q + AccW'(w_q[t]) + AccW'(pad_q);
            end
            MODE_COL: begin
              dy_q[t] <= pos_q[15:0];
              dx_q[t] <= 16'((cw_q - AccW'(w_q[t])) >> 1);
              pos_q   <= pos_q + AccW'(h_q[t]) + AccW'(pad_q);
            end
            MODE_GRID: begin
              dx_q[t] <= colx_q[gc_q[IdxW-1:0]];
              dy_q[t] <= rowy_q[gr_q];
              if (gc_q == cols - 5'd1) begin
                gc_q <= '0;
                gr_q <= gr_q + 4'd1;
              end else begin
                gc_q <= gc_q + 5'd1;
              end
            end
            default: ;
          endcase
        end
        k_q <= k_last ? '0 : k_q + 4'd1;
      end
      ST_EMIT: begin
        tile_number_o   <= res.tile_number;
        source_x_o      <= res.source_x;
        source_y_o      <= res.source_y;
        dest_x_o        <= res.dest_x;
        dest_y_o        <= res.dest_y;
        copy_width_o    <= res.copy_width;
        copy_height_o   <= res.copy_height;
        canvas_width_o  <= res.canvas_width;
        canvas_height_o <= res.canvas_height;
        canvas_left_o   <= res.canvas_left;
        canvas_top_o    <= res.canvas_top;
        last_result_o   <= res.last_result;
        k_q <= k_last ? '0 : k_q + 4'd1;
      end
      default: ;
    endcase
  end

  // format the rectangle for the tile drawn in this emit step
  always_comb begin
    ein.tile_number   = t_emit;
    ein.width         = w_q[t_emit];
    ein.height        = h_q[t_emit];
    ein.dx            = dx_q[t_emit];
    ein.dy            = dy_q[t_emit];
    ein.canvas_width  = cw_q[15:0];
    ein.canvas_height = ch_q[15:0];
    ein.canvas_left   = cl_q;
    ein.canvas_top    = ct_q;
    ein.canvas_ok     = ok_q;
    ein.last          = k_last;
  end

  wtlc_emit u_emit (
    .tile_i (ein),
    .res_o  (res)
  );

endmodule

[verif/tb_window_tile_layout_compositor.sv]
// Testbench for the window tile layout compositor.
// Drives tile sets through the command port, predicts every copy rectangle
// and compares it as a whole record. Depends on wtlc_pkg and the compositor RTL.
module tb_window_tile_layout_compositor;
  import wtlc_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [7:0]         cfg_data_i = '0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [15:0] tile_left_i = '0;
  logic signed [15:0] tile_top_i = '0;
  logic [13:0]        tile_width_i = '0;
  logic [13:0]        tile_height_i = '0;
  logic [15:0]        depth_order_i = '0;
  logic               last_tile_i = 1'b0;
  logic               result_valid_o;
  logic [3:0]         tile_number_o;
  logic [13:0]        source_x_o, source_y_o, copy_width_o, copy_height_o;
  logic [15:0]        dest_x_o, dest_y_o, canvas_width_o, canvas_height_o;
  logic signed [15:0] canvas_left_o, canvas_top_o;
  logic               last_result_o;

  window_tile_layout_compositor dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the configuration registers
  mode_e       mode_q;
  int          pad_q;
  int          cols_q;

  // tiles of the set being loaded
  int          t_left[MaxTiles], t_top[MaxTiles], t_w[MaxTiles], t_h[MaxTiles];
  int          t_depth[MaxTiles];
  int          n_loaded;

  result_t     rect_q[$];
  int          errors;
  int          n_mismatch;
  int          idle_cycles = 0;

  // Build the expected copy rectangles for the tiles now held.
  function automatic void compose_set();
    int order[MaxTiles];
    int dx[MaxTiles], dy[MaxTiles], colw[MaxTiles], rowh[MaxTiles];
    int colx[MaxTiles], rowy[MaxTiles];
    int n, cw, ch, cl, ct, mr, mb, pos, cols, rows, j, t, v;
    bit ok, rev;
    result_t r;
    n = n_loaded; cw = 0; ch = 0; cl = 0; ct = 0; rev = 0;
    // stable insertion sort on depth
    for (int i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && t_depth[order[j-1]] > t_depth[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (int i = 0; i < MaxTiles; i++) begin
      colw[i] = 0; rowh[i] = 0;
    end
    if (n == 1) begin
      cw = t_w[0]; ch = t_h[0]; cl = t_left[0]; ct = t_top[0];
      dx[0] = 0; dy[0] = 0;
      ok = cw > 0 && ch > 0;
    end else begin
      if (mode_q == MODE_BBOX) begin
        rev = 1;
        cl = t_left[0]; ct = t_top[0];
        mr = cl + t_w[0]; mb = ct + t_h[0];
        for (int i = 1; i < n; i++) begin
          if (t_left[i] < cl) cl = t_left[i];
          if (t_top[i] < ct) ct = t_top[i];
          if (t_left[i] + t_w[i] > mr) mr = t_left[i] + t_w[i];
          if (t_top[i] + t_h[i] > mb) mb = t_top[i] + t_h[i];
        end
        cw = mr - cl; ch = mb - ct;
        for (int i = 0; i < n; i++) begin
          dx[i] = t_left[i] - cl; dy[i] = t_top[i] - ct;
        end
      end else if (mode_q != MODE_GRID) begin
        for (int i = 0; i < n; i++) begin
          t = order[i];
          if (mode_q == MODE_ROW) begin
            cw += t_w[t] + (i + 1 < n ? pad_q : 0);
            if (t_h[t] > ch) ch = t_h[t];
          end else begin
            ch += t_h[t] + (i + 1 < n ? pad_q : 0);
            if (t_w[t] > cw) cw = t_w[t];
          end
        end
        cw += cw & 1; ch += ch & 1;
        pos = 0;
        for (int i = 0; i < n; i++) begin
          t = order[i];
          if (mode_q == MODE_ROW) begin
            dx[t] = pos; dy[t] = (ch - t_h[t]) / 2; pos += t_w[t] + pad_q;
          end else begin
            dy[t] = pos; dx[t] = (cw - t_w[t]) / 2; pos += t_h[t] + pad_q;
          end
        end
      end else begin
        cols = (cols_q == 0) ? 1 : cols_q;
        rows = (n + cols - 1) / cols;
        for (int i = 0; i < n; i++) begin
          t = order[i];
          if (t_w[t] > colw[i % cols]) colw[i % cols] = t_w[t];
          if (t_h[t] > rowh[i / cols]) rowh[i / cols] = t_h[t];
        end
        for (int c = 0; c < cols && c < n; c++) begin
          colx[c] = cw + c * pad_q; cw += colw[c];
        end
        for (int c = 0; c < rows; c++) begin
          rowy[c] = ch + c * pad_q; ch += rowh[c];
        end
        cw += pad_q * (cols - 1);
        ch += pad_q * (rows - 1);
        for (int i = 0; i < n; i++) begin
          t = order[i];
          dx[t] = colx[i % cols]; dy[t] = rowy[i / cols];
        end
      end
      cw += cw & 1; ch += ch & 1;
      if (mode_q != MODE_BBOX) begin
        cl = 0; ct = 0;
      end
      ok = cw > 0 && ch > 0 && cw <= 65535 && ch <= 65535;
    end
    for (int i = 0; i < n; i++) begin
      t = rev ? order[n-1-i] : order[i];
      r = '0;
      r.tile_number = 4'(t);
      r.last_result = (i + 1 == n);
      if (ok) begin
        r.canvas_width = 16'(cw); r.canvas_height = 16'(ch);
        r.canvas_left = 16'(cl); r.canvas_top = 16'(ct);
        if (t_w[t] > 0 && t_h[t] > 0) begin
          r.dest_x = 16'(dx[t]); r.dest_y = 16'(dy[t]);
          r.copy_width = 14'(t_w[t]); r.copy_height = 14'(t_h[t]);
        end
      end
      rect_q.push_back(r);
    end
    n_loaded = 0;
  endfunction

  // Send one tile; hold start until the block takes it.
  task automatic send_tile(int left, int top, int w, int h, int depth, bit last);
    int gap;
    gap = $urandom_range(0, 13);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    tile_left_i   <= 16'(left);
    tile_top_i    <= 16'(top);
    tile_width_i  <= 14'(w);
    tile_height_i <= 14'(h);
    depth_order_i <= 16'(depth);
    last_tile_i   <= last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    // accepted at this edge: record the tile and predict if it closes the set
    if (n_loaded < MaxTiles) begin
      t_left[n_loaded] = $signed(16'(left)); t_top[n_loaded] = $signed(16'(top));
      t_w[n_loaded] = w & 16'h3fff; t_h[n_loaded] = h & 16'h3fff;
      t_depth[n_loaded] = depth & 16'hffff;
      n_loaded++;
    end
    if (last) compose_set();
  endtask

  // Drop start, drain outstanding rectangles, then settle before touching registers.
  task automatic wait_idle();
    start_i <= 1'b0;
    while (rect_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= 8'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgLayoutMode:  mode_q = mode_e'(val[1:0]);
      CfgPadding:     pad_q = val & 8'hff;
      CfgGridColumns: cols_q = val & 5'h1f;
      default: ;
    endcase
  endtask

  task automatic set_config(mode_e m, int pad, int cols);
    write_reg(CfgLayoutMode, m);
    write_reg(CfgPadding, pad);
    write_reg(CfgGridColumns, cols);
  endtask

  // Random set of n tiles; size mostly small, sometimes extreme.
  task automatic send_random_set(int n);
    int w, h;
    for (int i = 0; i < n; i++) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 300);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 300);
      send_tile($urandom, $urandom, w, h,
                ($urandom_range(0, 1)) ? $urandom_range(0, 3) : $urandom, i == n - 1);
    end
  endtask

  // Extremes of position, size and depth, single tile, empty tile.
  task automatic test_directed();
    send_tile(-32768, 32767, 16383, 16383, 65535, 1);   // single tile passthrough
    send_tile(5, 7, 0, 9, 0, 1);                        // single empty tile fails
    send_tile(-32768, -32768, 16383, 1, 3, 0);          // bounding box, ties
    send_tile(32767, 32767, 3, 16383, 3, 0);
    send_tile(0, 0, 0, 0, 0, 1);
    send_tile(10, 20, 5, 5, 9, 0);
    send_tile(12, 21, 7, 3, 1, 1);
  endtask

  task automatic test_row_column();
    set_config(MODE_ROW, 255, 2);
    send_tile(0, 0, 16383, 16383, 0, 0);                // overflows the canvas
    send_tile(0, 0, 16383, 7, 0, 0);
    send_tile(0, 0, 16383, 7, 0, 0);
    send_tile(0, 0, 16383, 7, 0, 0);
    send_tile(0, 0, 16383, 7, 1, 1);
    set_config(MODE_COL, 0, 2);
    send_tile(1, 1, 3, 5, 2, 0);
    send_tile(1, 1, 8, 1, 1, 1);
  endtask

  task automatic test_grid();
    set_config(MODE_GRID, 3, 0);                        // zero columns acts as one
    send_random_set(3);
    write_reg(CfgGridColumns, 16);
    send_random_set(5);
    write_reg(CfgGridColumns, 31);
    send_random_set(4);
  endtask

  // More than sixteen tiles: the extras drop, the last one still closes.
  task automatic test_overflow();
    set_config(MODE_GRID, 1, 4);
    send_random_set(19);
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 120) begin
      set_config(mode_e'($urandom_range(0, 3)), $urandom_range(0, 255),
                 $urandom_range(0, 31));
      for (int s = 0; s < 4; s++) begin
        int n;
        n = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 6);
        send_random_set(n);
        sent += n;
      end
    end
  endtask

  // Compare each rectangle with the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      result_t act, exp_r;
      act = '{tile_number_o, source_x_o, source_y_o, dest_x_o, dest_y_o,
              copy_width_o, copy_height_o, canvas_width_o, canvas_height_o,
              canvas_left_o, canvas_top_o, last_result_o};
      if (rect_q.size() == 0) begin
        errors++;
        if (n_mismatch++ < 10) $display("unexpected rectangle %p", act);
      end else begin
        exp_r = rect_q.pop_front();
        if (act !== exp_r) begin
          errors++;
          if (n_mismatch++ < 10) $display("mismatch exp %p act %p", exp_r, act);
        end
      end
    end
  end

  // Watchdog: count cycles with nothing accepted or emitted.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    mode_q = MODE_BBOX; pad_q = 8; cols_q = 2;
    n_loaded = 0; errors = 0; n_mismatch = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_row_column();
    test_grid();
    test_overflow();
    test_random();
    wait_idle();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
